// ===== hdl/shamd_pkg.sv =====
`default_nettype none

package shamd_pkg;

  localparam int QueueDepth = 4;

  localparam logic [31:0] PadWord = 32'h8000_0000;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic        is_last;
  } shamd_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_PAD,
    F_ZERO,
    F_LENLO
  } shamd_front_state_t;

  typedef enum logic [1:0] {
    B_COLLECT,
    B_ROUND,
    B_ADD,
    B_DIGEST
  } shamd_back_state_t;

  function automatic logic [31:0] big_sigma0(logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/shamd_front.sv =====
`default_nettype none

module shamd_front
  import shamd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [31:0]  in_data_word,
  input  wire logic [2:0]   in_valid_bytes,
  input  wire logic         in_last_word,
  output logic              q_push,
  output shamd_entry_t      q_entry,
  input  wire logic         q_full
);

  shamd_front_state_t state_r, state_nxt;
  logic [63:0]        bitlen_r, bitlen_nxt;
  logic [3:0]         slot_r, slot_nxt;
  logic [2:0]         nbytes;
  logic [31:0]        keep_mask;
  logic [31:0]        pad_bit;

  assign nbytes   = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
  assign in_stall = (state_r != F_IDLE) || q_full;

  always_comb begin
    unique case (nbytes[1:0])
      2'd0: begin
        keep_mask = 32'h0000_0000;
        pad_bit   = 32'h8000_0000;
      end
      2'd1: begin
        keep_mask = 32'hff00_0000;
        pad_bit   = 32'h0080_0000;
      end
      2'd2: begin
        keep_mask = 32'hffff_0000;
        pad_bit   = 32'h0000_8000;
      end
      2'd3: begin
        keep_mask = 32'hffff_ff00;
        pad_bit   = 32'h0000_0080;
      end
    endcase
  end

  always_comb begin
    state_nxt        = state_r;
    bitlen_nxt       = bitlen_r;
    slot_nxt         = slot_r;
    q_push           = 1'b0;
    q_entry.word     = '0;
    q_entry.is_last  = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid && !q_full) begin
          q_push   = 1'b1;
          slot_nxt = slot_r + 4'd1;
          if (!in_last_word) begin
            q_entry.word = in_data_word;
            bitlen_nxt   = bitlen_r + 64'd32;
          end else begin
            bitlen_nxt = bitlen_r + {58'd0, nbytes, 3'd0};
            if (nbytes == 3'd4) begin
              q_entry.word = in_data_word;
              state_nxt    = F_PAD;
            end else begin
              q_entry.word = (in_data_word & keep_mask) | pad_bit;
              state_nxt    = F_ZERO;
            end
          end
        end
      end
      F_PAD: begin
        if (!q_full) begin
          q_push       = 1'b1;
          q_entry.word = PadWord;
          slot_nxt     = slot_r + 4'd1;
          state_nxt    = F_ZERO;
        end
      end
      F_ZERO: begin
        if (!q_full) begin
          q_push   = 1'b1;
          slot_nxt = slot_r + 4'd1;
          if (slot_r == 4'd14) begin
            q_entry.word = bitlen_r[63:32];
            state_nxt    = F_LENLO;
          end
        end
      end
      F_LENLO: begin
        if (!q_full) begin
          q_push          = 1'b1;
          q_entry.word    = bitlen_r[31:0];
          q_entry.is_last = 1'b1;
          slot_nxt        = slot_r + 4'd1;
          bitlen_nxt      = '0;
          state_nxt       = F_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      bitlen_r <= '0;
      slot_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      bitlen_r <= bitlen_nxt;
      slot_r   <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/shamd_queue.sv =====
`default_nettype none

module shamd_queue
  import shamd_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire shamd_entry_t push_entry,
  output logic              full,
  input  wire logic         pop,
  output shamd_entry_t      pop_entry,
  output logic              not_empty
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  shamd_entry_t    mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push, do_pop;

  assign full      = (count_r == CntW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("word pushed into a full queue");

endmodule

`default_nettype wire

// ===== hdl/shamd_back.sv =====
`default_nettype none

module shamd_back
  import shamd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_valid,
  input  wire shamd_entry_t q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [31:0]       out_digest_word,
  output logic              out_digest_last
);

  shamd_back_state_t state_r, state_nxt;
  logic [31:0] win_r  [16];
  logic [31:0] win_nxt [16];
  logic [31:0] hash_r [8];
  logic [31:0] hash_nxt [8];
  logic [31:0] work_r [8];
  logic [31:0] work_nxt [8];
  logic [3:0]  cnt_r, cnt_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        is_last_r, is_last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic        out_last_r, out_last_nxt;
  logic [31:0] t1, t2, ch, maj, w_new;
  logic        load_out;

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_digest_last = out_last_r;
  assign load_out        = !out_valid_r || !out_stall;

  assign ch    = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign maj   = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
  assign t1    = work_r[7] + big_sigma1(work_r[4]) + ch + RoundK[rnd_r] + win_r[0];
  assign t2    = big_sigma0(work_r[0]) + maj;
  assign w_new = small_sigma1(win_r[14]) + win_r[9] + small_sigma0(win_r[1]) + win_r[0];

  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    hash_nxt      = hash_r;
    work_nxt      = work_r;
    cnt_nxt       = cnt_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    is_last_nxt   = is_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    unique case (state_r)
      B_COLLECT: begin
        if (q_valid) begin
          q_pop = 1'b1;
          for (int i = 0; i < 15; i++) begin
            win_nxt[i] = win_r[i+1];
          end
          win_nxt[15] = q_entry.word;
          cnt_nxt     = cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            is_last_nxt = q_entry.is_last;
            work_nxt    = hash_r;
            rnd_nxt     = '0;
            state_nxt   = B_ROUND;
          end
        end
      end
      B_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[15] = w_new;
        work_nxt[7] = work_r[6];
        work_nxt[6] = work_r[5];
        work_nxt[5] = work_r[4];
        work_nxt[4] = work_r[3] + t1;
        work_nxt[3] = work_r[2];
        work_nxt[2] = work_r[1];
        work_nxt[1] = work_r[0];
        work_nxt[0] = t1 + t2;
        rnd_nxt     = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = B_ADD;
        end
      end
      B_ADD: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + work_r[i];
        end
        if (is_last_r) begin
          idx_nxt   = '0;
          state_nxt = B_DIGEST;
        end else begin
          state_nxt = B_COLLECT;
        end
      end
      B_DIGEST: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = hash_r[idx_r];
          out_last_nxt  = (idx_r == 3'd7);
          idx_nxt       = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            hash_nxt  = InitHash;
            state_nxt = B_COLLECT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    is_last_r  <= is_last_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_COLLECT;
      hash_r      <= InitHash;
      work_r      <= '{default: '0};
      cnt_r       <= '0;
      rnd_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      work_r      <= work_nxt;
      cnt_r       <= cnt_nxt;
      rnd_r       <= rnd_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ROUND && rnd_r == 6'd63) |=> state_r == B_ADD)
    else $error("compression did not end after the final round");

  a_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ADD && !is_last_r) |=> (state_r == B_COLLECT && cnt_r == 4'd0))
    else $error("word count not aligned to a block boundary");

  a_hash_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIGEST && state_nxt == B_COLLECT)
      |=> (hash_r[0] == InitHash[0] && hash_r[7] == InitHash[7]))
    else $error("hash state not restored after the digest");

endmodule

`default_nettype wire

// ===== hdl/sha256_message_digest.sv =====
// Channel  Direction  Ports                                                 Handshake
// in       input      in_data_word[32] in_valid_bytes[3] in_last_word[1]    in_valid/in_stall
// out      output     out_digest_word[32] out_digest_last[1]                out_valid/out_stall
//
// The back end handles a block of sixteen words in steps: it collects them, runs 64 rounds and
// adds the result into the hash state, and it pops no words from the queue while it rounds or adds.
// A last word adds up to 18 padding words from the front end, then eight digest beats.
// Reset is synchronous and active low and restores the initial hash values at once.
// The front end keeps taking words into the queue, until it is full, while the back end compresses
// or waits on a stalled digest beat.
`default_nettype none

module sha256_message_digest
  import shamd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic        in_last_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic             out_digest_last
);

  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;
  shamd_entry_t q_push_entry;
  shamd_entry_t q_pop_entry;

  shamd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last_word   (in_last_word),
    .q_push         (q_push),
    .q_entry        (q_push_entry),
    .q_full         (q_full)
  );

  shamd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_pop_entry),
    .not_empty  (q_valid)
  );

  shamd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_entry         (q_pop_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_digest_last (out_digest_last)
  );

endmodule

`default_nettype wire
